[rtl/core/ffade_pkg.sv]
// ---------------------------------------------------------------------------
// Frustum fade test package
// Shared field widths, command and status codes, and pipeline structs.
// ---------------------------------------------------------------------------
package ffade_pkg;

	localparam int W      = 32;
	localparam int DIS_W  = 17;
	localparam int MASK_W = 6;
	localparam int PIX_W  = 3;

	typedef enum logic [1:0] {
		CMD_PLANE = 2'd0,
		CMD_VIEW  = 2'd1,
		CMD_TEST  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK   = 3'd0,
		ST_VIEW = 3'd1,
		ST_BOX  = 3'd2,
		ST_MASK = 3'd3,
		ST_OVF  = 3'd4
	} status_t;

	// request control carried from stage 2 to the plane merge
	typedef struct packed {
		logic                zero;
		status_t             status;
		logic [MASK_W-1:0]   mask;
	} ctl_t;

	// per plane support distances, plain and expanded
	typedef struct packed {
		logic                ovf;
		logic signed [W-1:0] s;
		logic signed [W-1:0] x;
	} sup_t;

	// merged result waiting for the dissolve pipeline
	typedef struct packed {
		logic                zero;
		status_t             status;
		logic                cull;
		logic signed [W-1:0] min_s;
	} res_t;

endpackage

[rtl/core/frustum_aabb_fade_test_top.sv]
// ---------------------------------------------------------------------------
// Frustum box cull with dissolve band
// Plane store, per plane support pipelines, merge and dissolve pipelines.
// ---------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | cmd view plane_index plane_mask coord_* extent_*
//  out     | out_valid / out_stall| culled dissolve boundary_distance status
//
//  One request per cycle while the output is not stalled. The depth is set
//  by the dissolve divider, which
//  retires one quotient bit per stage.
//  Reset clears the plane valid bits, view flags, margins and the pipeline
//  valid chain; a plane never written reads as zero, so no clearing pass.
//  A stall on a valid output freezes the whole pipeline; in_stall follows it.
//
module frustum_aabb_fade_test_top import ffade_pkg::*; #(
	parameter int VIEWS     = 2,
	parameter int PLANES    = 6,
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic [0:0]          view,
	input  logic [PIX_W-1:0]    plane_index,
	input  logic [MASK_W-1:0]   plane_mask,
	input  logic signed [W-1:0] coord_x,
	input  logic signed [W-1:0] coord_y,
	input  logic signed [W-1:0] coord_z,
	input  logic signed [W-1:0] coord_w,
	input  logic signed [W-1:0] extent_x,
	input  logic signed [W-1:0] extent_y,
	input  logic signed [W-1:0] extent_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                culled,
	output logic [DIS_W-1:0]    dissolve,
	output logic signed [W-1:0] boundary_distance,
	output logic [2:0]          status
);

	localparam int VIX = (VIEWS > 1) ? $clog2(VIEWS) : 1;
	localparam int F   = FRAC_BITS;
	localparam int LAT = F + 9;
	localparam int SD  = F + 3;
	localparam logic [MASK_W-1:0] PMASK = MASK_W'((1 << PLANES) - 1);
	localparam logic [F+1:0]      ONE   = (F+2)'(1) << F;

	logic              adv;
	logic              acc;
	logic [LAT:1]      vld_q;

	logic              view_ok;
	logic [VIX-1:0]    vidx;
	logic [VIX-1:0]    raddr;
	logic [PLANES-1:0] we_p;
	logic [PLANES-1:0] pv_row;

	logic [VIEWS*PLANES-1:0] pv_q;
	logic                    vvalid_q [VIEWS];
	logic signed [W-1:0]     vmargin_q [VIEWS];

	// stage 1
	cmd_t                cmd_s1;
	logic [MASK_W-1:0]   mask_s1;
	logic signed [W-1:0] c_s1 [3];
	logic [W-1:0]        e_s1 [3];
	logic                vok_s1;
	logic signed [W-1:0] margin_s1;
	logic [PLANES-1:0]   pv_s1;
	logic [4*W-1:0]      row_s1 [PLANES];
	logic [W-1:0]        margin_pos;

	ctl_t ctl_d;
	ctl_t ctl_q [4];

	sup_t              sup [PLANES];
	logic              fact [PLANES];
	logic [F+1:0]      fsm [PLANES];

	logic                ovf_any;
	logic signed [W-1:0] min_s;
	logic signed [W-1:0] min_x;
	res_t                side_d;
	res_t                side_q [SD];

	logic [F+1:0]        dmax;
	logic [F+1:0]        dpl;

	// Hold everything while a finished result waits under stall.
	assign adv      = !vld_q[LAT] || !out_stall;
	assign in_stall = !adv;
	assign acc      = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-1:1], in_valid};
		end
	end

	assign out_valid = vld_q[LAT];

	// ---- plane store and view registers -------------------------------
	assign view_ok = int'(view) < VIEWS;
	assign vidx    = VIX'(view);
	assign raddr   = view_ok ? vidx : '0;

	for (genvar p = 0; p < PLANES; p++) begin : g_store
		assign we_p[p] = acc && (cmd == CMD_PLANE) && view_ok &&
		                 (plane_index == PIX_W'(p));

		ffade_ram #(
			.WIDTH (4*W),
			.DEPTH (VIEWS)
		) u_ram (
			.clk   (clk),
			.we    (we_p[p]),
			.waddr (vidx),
			.wdata ({coord_w, coord_z, coord_y, coord_x}),
			.re    (acc),
			.raddr (raddr),
			.rdata (row_s1[p])
		);
	end

	// Mark a plane written; an unwritten plane reads as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= '0;
			for (int v = 0; v < VIEWS; v++) begin
				vvalid_q[v]  <= 1'b0;
				vmargin_q[v] <= '0;
			end
		end else begin
			for (int v = 0; v < VIEWS; v++) begin
				for (int p = 0; p < PLANES; p++) begin
					if (we_p[p] && (vidx == VIX'(v))) begin
						pv_q[v*PLANES+p] <= 1'b1;
					end
				end
			end
			if (acc && (cmd == CMD_VIEW) && view_ok) begin
				vvalid_q[vidx]  <= plane_mask[0];
				vmargin_q[vidx] <= coord_w;
			end
		end
	end

	always_comb begin
		pv_row = '0;
		for (int v = 0; v < VIEWS; v++) begin
			if (raddr == VIX'(v)) begin
				pv_row = pv_q[v*PLANES +: PLANES];
			end
		end
	end

	// ---- stage 1: capture the request next to the store read -----------
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1    <= cmd_t'(cmd);
			mask_s1   <= plane_mask;
			c_s1[0]   <= coord_x;
			c_s1[1]   <= coord_y;
			c_s1[2]   <= coord_z;
			e_s1[0]   <= extent_x;
			e_s1[1]   <= extent_y;
			e_s1[2]   <= extent_z;
			vok_s1    <= view_ok && vvalid_q[raddr];
			margin_s1 <= vmargin_q[raddr];
			pv_s1     <= pv_row;
		end
	end

	// Widen extents only by a positive margin.
	assign margin_pos = (!margin_s1[W-1] && (|margin_s1)) ? margin_s1 : '0;

	// ---- stage 2..5: request checks travel beside the plane pipelines --
	always_comb begin
		ctl_d.mask   = mask_s1 & PMASK;
		ctl_d.zero   = 1'b1;
		ctl_d.status = ST_OK;
		if (cmd_s1 == CMD_TEST) begin
			if (!vok_s1) begin
				ctl_d.status = ST_VIEW;
			end else if (e_s1[0][W-1] || e_s1[1][W-1] || e_s1[2][W-1]) begin
				ctl_d.status = ST_BOX;
			end else if ((mask_s1 & PMASK) == '0) begin
				ctl_d.status = ST_MASK;
			end else begin
				ctl_d.zero = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_q[0] <= ctl_d;
			for (int j = 1; j < 4; j++) begin
				ctl_q[j] <= ctl_q[j-1];
			end
		end
	end

	for (genvar p = 0; p < PLANES; p++) begin : g_plane
		logic signed [W-1:0] n_p [4];

		for (genvar k = 0; k < 4; k++) begin : g_word
			assign n_p[k] = pv_s1[p] ? row_s1[p][k*W +: W] : '0;
		end

		ffade_plane #(
			.FRAC_BITS (FRAC_BITS)
		) u_plane (
			.clk        (clk),
			.en         (adv),
			.n          (n_p),
			.c          (c_s1),
			.e          (e_s1),
			.margin_pos (margin_pos),
			.sup        (sup[p])
		);

		ffade_fade #(
			.FRAC_BITS (FRAC_BITS)
		) u_fade (
			.clk (clk),
			.en  (adv),
			.enb (ctl_q[3].mask[p]),
			.sup (sup[p]),
			.act (fact[p]),
			.sm  (fsm[p])
		);
	end

	// ---- stage 6: merge planes -----------------------------------------
	always_comb begin
		ovf_any = 1'b0;
		min_s   = {1'b0, {(W-1){1'b1}}};
		min_x   = {1'b0, {(W-1){1'b1}}};
		for (int p = 0; p < PLANES; p++) begin
			if (ctl_q[3].mask[p]) begin
				ovf_any = ovf_any | sup[p].ovf;
				if (sup[p].s < min_s) begin
					min_s = sup[p].s;
				end
				if (sup[p].x < min_x) begin
					min_x = sup[p].x;
				end
			end
		end
		side_d.zero   = ctl_q[3].zero || ovf_any;
		side_d.status = ctl_q[3].zero ? ctl_q[3].status : (ovf_any ? ST_OVF : ST_OK);
		side_d.cull   = min_x <= 0;
		side_d.min_s  = min_s;
	end

	// Delay the merged result to meet the dissolve pipelines.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= side_d;
			for (int j = 1; j < SD; j++) begin
				side_q[j] <= side_q[j-1];
			end
		end
	end

	// Take the largest plane dissolve.
	always_comb begin
		dmax = '0;
		for (int p = 0; p < PLANES; p++) begin
			dpl = (fact[p] && (fsm[p] < ONE)) ? ONE - fsm[p] : '0;
			if (dpl > dmax) begin
				dmax = dpl;
			end
		end
	end

	// ---- output register -------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_q[SD-1].zero) begin
				culled            <= 1'b0;
				dissolve          <= '0;
				boundary_distance <= '0;
				status            <= side_q[SD-1].status;
			end else if (side_q[SD-1].cull) begin
				culled            <= 1'b1;
				dissolve          <= DIS_W'(ONE);
				boundary_distance <= side_q[SD-1].min_s;
				status            <= ST_OK;
			end else begin
				culled            <= 1'b0;
				dissolve          <= DIS_W'(dmax);
				boundary_distance <= side_q[SD-1].min_s;
				status            <= ST_OK;
			end
		end
	end

endmodule

[rtl/core/ffade_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ffade_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/ffade_plane.sv]
// ---------------------------------------------------------------------------
// Plane support unit
// Four stage pipeline forming S = n.c + d + |n|.e and the expanded E.
// ---------------------------------------------------------------------------
module ffade_plane import ffade_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] n [4],
	input  logic signed [W-1:0] c [3],
	input  logic [W-1:0]        e [3],
	input  logic [W-1:0]        margin_pos,
	output sup_t                sup
);

	localparam int PW = 64;

	logic signed [W-1:0]    n_s1 [3];
	logic [W-1:0]           nm_s1 [3];
	logic signed [W-1:0]    c_s1 [3];
	logic [W-1:0]           e_s1 [3];
	logic [W:0]             ex_s1 [3];
	logic signed [W-1:0]    d_s1;

	logic signed [PW-1:0]   pc_s2 [3];
	logic [PW-1:0]          pe_s2 [3];
	logic [PW:0]            px_s2 [3];
	logic signed [W-1:0]    d_s2;

	logic signed [PW-1:0]   cd_s3;
	logic [PW-1:0]          r_s3;
	logic [PW-1:0]          rx_s3;

	logic signed [PW-1:0]   cd_c;
	logic [PW-1:0]          r_c;
	logic [PW-1:0]          rx_c;
	logic signed [PW-1:0]   s_c;
	logic signed [PW-1:0]   x_c;

	// stage 1: magnitudes and margin widened extents
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				n_s1[k]  <= n[k];
				nm_s1[k] <= n[k][W-1] ? W'(-n[k]) : n[k];
				c_s1[k]  <= c[k];
				e_s1[k]  <= e[k];
				ex_s1[k] <= {1'b0, e[k]} + {1'b0, margin_pos};
			end
			d_s1 <= n[3];
		end
	end

	// stage 2: exact products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pc_s2[k] <= n_s1[k] * c_s1[k];
				pe_s2[k] <= nm_s1[k] * e_s1[k];
				px_s2[k] <= nm_s1[k] * ex_s1[k];
			end
			d_s2 <= d_s1;
		end
	end

	// stage 3: floor shifts and partial sums
	always_comb begin
		cd_c = PW'(d_s2);
		r_c  = '0;
		rx_c = '0;
		for (int k = 0; k < 3; k++) begin
			cd_c = cd_c + (pc_s2[k] >>> FRAC_BITS);
			r_c  = r_c + (pe_s2[k] >> FRAC_BITS);
			rx_c = rx_c + PW'(px_s2[k] >> FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cd_s3 <= cd_c;
			r_s3  <= r_c;
			rx_s3 <= rx_c;
		end
	end

	// stage 4: final sums and range check
	assign s_c = cd_s3 + signed'(r_s3);
	assign x_c = cd_s3 + signed'(rx_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			sup.s   <= s_c[W-1:0];
			sup.x   <= x_c[W-1:0];
			sup.ovf <= !((&s_c[PW-1:W-1]) || !(|s_c[PW-1:W-1])) ||
			           !((&x_c[PW-1:W-1]) || !(|x_c[PW-1:W-1]));
		end
	end

endmodule

[rtl/core/ffade_fade.sv]
// ---------------------------------------------------------------------------
// Plane dissolve unit
// Bit per stage divider for t = E / (E - S), then the smoothstep products.
// ---------------------------------------------------------------------------
module ffade_fade import ffade_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic                 enb,
	input  sup_t                 sup,
	output logic                 act,
	output logic [FRAC_BITS+1:0] sm
);

	localparam int F = FRAC_BITS;

	logic [W-1:0]   rem_q [F+1];
	logic [W-1:0]   dv_q  [F+1];
	logic [F-1:0]   q_q   [F+1];
	logic           act_q [F+1];

	logic [F-1:0]   t_u;
	logic [F-1:0]   u_u;
	logic           act_u;
	logic [F+1:0]   k_c;

	// divider entry: the band is below 2^32 and the remainder starts below it
	always_ff @(posedge clk) begin
		if (en) begin
			act_q[0] <= enb && sup.s[W-1] && !sup.x[W-1] && (|sup.x);
			dv_q[0]  <= W'(sup.x) - W'(sup.s);
			rem_q[0] <= W'(sup.x);
			q_q[0]   <= '0;
		end
	end

	for (genvar i = 0; i < F; i++) begin : g_div
		logic [W:0] r2;
		logic       ge;

		assign r2 = {rem_q[i], 1'b0};
		assign ge = r2 >= {1'b0, dv_q[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i+1] <= ge ? W'(r2 - {1'b0, dv_q[i]}) : W'(r2);
				dv_q[i+1]  <= dv_q[i];
				q_q[i+1]   <= {q_q[i][F-2:0], ge};
				act_q[i+1] <= act_q[i];
			end
		end
	end

	// t squared
	always_ff @(posedge clk) begin
		if (en) begin
			u_u   <= F'(((2*F)'(q_q[F]) * (2*F)'(q_q[F])) >> F);
			t_u   <= q_q[F];
			act_u <= act_q[F];
		end
	end

	assign k_c = ((F+2)'(3) << F) - {1'b0, t_u, 1'b0};

	// u * (3 - 2t)
	always_ff @(posedge clk) begin
		if (en) begin
			sm  <= (F+2)'(((2*F+2)'(u_u) * (2*F+2)'(k_c)) >> F);
			act <= act_u;
		end
	end

endmodule

[rtl/core/ffade_checker.sv]
// ---------------------------------------------------------------------------
// Frustum fade test checker
// Port level checks on result consistency and backpressure.
// ---------------------------------------------------------------------------
module ffade_checker import ffade_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic                culled,
	input logic [DIS_W-1:0]    dissolve,
	input logic signed [W-1:0] boundary_distance,
	input logic [2:0]          status
);

	localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(culled) && $stable(dissolve) &&
		$stable(boundary_distance) && $stable(status))
		else $error("stalled result changed");

	// an empty output never backpressures the input
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_cull: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && culled |-> dissolve == ONE[DIS_W-1:0] && status == ST_OK)
		else $error("culled box without full dissolve");

	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> !culled && dissolve == '0 &&
		boundary_distance == '0)
		else $error("failed test carries data");

endmodule

bind frustum_aabb_fade_test_top ffade_checker #(.FRAC_BITS(FRAC_BITS)) u_ffade_checker (.*);
